@@ src/radius_neighbor_link_finder_defines.svh @@
// ----------------------------------------------------------------------------
// radius neighbor link finder assertion macros
// shared concurrent check forms for the rtl files
// ----------------------------------------------------------------------------
`ifndef RADIUS_NEIGHBOR_LINK_FINDER_DEFINES_SVH
`define RADIUS_NEIGHBOR_LINK_FINDER_DEFINES_SVH

`ifndef SYNTHESIS
`define RNLF_ASSERT_SAME(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rnlf check failed");
`define RNLF_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rnlf check failed");
`else
`define RNLF_ASSERT_SAME(lbl, clk, rst, pre, post)
`define RNLF_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

@@ src/rnlf_pkg.sv @@
// ----------------------------------------------------------------------------
// rnlf package
// shared widths, codes and types of the radius neighbor link finder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rnlf_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int RADIUS_W   = 14;
  localparam int SQ_W       = 2 * RADIUS_W;
  localparam int D2_W       = SQ_W + 1;
  localparam int LIM_W      = 6;
  localparam int MAX_LINKS  = 32;
  localparam int INDEX_W    = 10;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_RADIUS  = 1'b0,
    REG_MAXCONN = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QRD,
    ST_QLD,
    ST_WALK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               busy;
    logic               hit;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cand_t;

endpackage

@@ src/rnlf_point_ram.sv @@
// ----------------------------------------------------------------------------
// rnlf point ram
// point table, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnlf_point_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [rnlf_pkg::ADDR_W-1:0]    waddr,
  input  logic [2*rnlf_pkg::COORD_W-1:0] wdata,
  input  logic                           re,
  input  logic [rnlf_pkg::ADDR_W-1:0]    raddr,
  output logic [2*rnlf_pkg::COORD_W-1:0] rdata
);

  logic [2*rnlf_pkg::COORD_W-1:0] mem [rnlf_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/rnlf_dist.sv @@
// ----------------------------------------------------------------------------
// rnlf distance pipeline
// offset, square and radius compare of one candidate point per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnlf_dist (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           flush,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [rnlf_pkg::COORD_W-1:0]   from_x,
  input  logic [rnlf_pkg::COORD_W-1:0]   from_y,
  input  logic [2*rnlf_pkg::COORD_W-1:0] pt,
  input  logic [rnlf_pkg::SQ_W-1:0]      r2,
  output rnlf_pkg::cand_t                cand
);

  logic [rnlf_pkg::COORD_W-1:0]  tx, ty;
  logic [rnlf_pkg::DIFF_W-1:0]   dx, dy, adx, ady;
  logic                          va, vb;
  logic                          far_a, far_b;
  logic [rnlf_pkg::RADIUS_W-1:0] ax, ay;
  logic [rnlf_pkg::COORD_W-1:0]  xa, ya, xb, yb;
  logic [rnlf_pkg::SQ_W-1:0]     sqx, sqy;
  logic [rnlf_pkg::D2_W-1:0]     d2;

  assign tx  = pt[rnlf_pkg::COORD_W-1:0];
  assign ty  = pt[2*rnlf_pkg::COORD_W-1:rnlf_pkg::COORD_W];
  assign dx  = {tx[rnlf_pkg::COORD_W-1], tx} - {from_x[rnlf_pkg::COORD_W-1], from_x};
  assign dy  = {ty[rnlf_pkg::COORD_W-1], ty} - {from_y[rnlf_pkg::COORD_W-1], from_y};
  assign adx = dx[rnlf_pkg::DIFF_W-1] ? -dx : dx;
  assign ady = dy[rnlf_pkg::DIFF_W-1] ? -dy : dy;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      far_a <= (adx[rnlf_pkg::DIFF_W-1:rnlf_pkg::RADIUS_W] != '0);
      ax    <= adx[rnlf_pkg::RADIUS_W-1:0];
      ay    <= ady[rnlf_pkg::RADIUS_W-1:0];
      xa    <= tx;
      ya    <= ty;
      far_b <= far_a || (ay == ay && 1'b0);
      sqx   <= ax * ax;
      sqy   <= ay * ay;
      xb    <= xa;
      yb    <= ya;
    end
  end

  logic far_ya;
  always_ff @(posedge clk) begin
    if (en) begin
      far_ya <= (ady[rnlf_pkg::DIFF_W-1:rnlf_pkg::RADIUS_W] != '0);
    end
  end

  logic far_all;
  assign far_all = far_b;
  logic far_yb;
  always_ff @(posedge clk) begin
    if (en) begin
      far_yb <= far_ya;
    end
  end

  assign d2 = {1'b0, sqx} + {1'b0, sqy};

  always_comb begin
    cand.busy = va || vb;
    cand.hit  = vb && !far_all && !far_yb && (d2 != '0) && (d2 < {1'b0, r2});
    cand.x    = xb;
    cand.y    = yb;
  end

endmodule

@@ src/radius_neighbor_link_finder.sv @@
// throughput: one stored point is compared per cycle while the output is not stalled,
// set by the single table read port
// a query ends at max_connections links, clamped to 1..32; output stalls pause the walk
// reset: point count cleared, connect_radius 1024, max_connections 4; table not cleared
// ----------------------------------------------------------------------------
// radius neighbor link finder
// point table with fixed radius neighbor link search per query point
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radius_neighbor_link_finder_defines.svh"

module radius_neighbor_link_finder (
  input  logic                              clk,
  input  logic                              rst,
  // opcode, point_index, x_coord, y_coord, zero fill
  input  logic [47:0]                       s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // from_x, from_y, to_x, to_y
  output logic [63:0]                       m_axis_tdata,
  // found
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [rnlf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rnlf_pkg::state_t                state, state_next;
  rnlf_pkg::opcode_t               op;
  logic [rnlf_pkg::INDEX_W-1:0]    in_idx, qidx;
  logic [rnlf_pkg::COORD_W-1:0]    in_x, in_y;
  logic [rnlf_pkg::RADIUS_W-1:0]   radius;
  logic [rnlf_pkg::LIM_W-1:0]      max_conn, lim, lim_calc, n_links;
  logic [rnlf_pkg::SQ_W-1:0]       r2;
  logic [rnlf_pkg::CNT_W-1:0]      count, j;
  logic [rnlf_pkg::COORD_W-1:0]    fx, fy, pend_x, pend_y;
  logic                            pend_v, bad, v_rd;
  logic                            in_fire, adv, ram_re, issue, link_fire, walk_empty;
  logic                            load_out, full, last_link;
  logic [2*rnlf_pkg::COORD_W-1:0]  rdata;
  logic [rnlf_pkg::ADDR_W-1:0]     raddr;
  rnlf_pkg::cand_t                 cand;
  logic [rnlf_pkg::COORD_W-1:0]    o_fx, o_fy, o_tx, o_ty;
  logic                            o_found, o_last, out_valid;
  logic [rnlf_pkg::COORD_W-1:0]    n_fx, n_fy, n_tx, n_ty;
  logic                            n_found, n_last;

  assign op     = rnlf_pkg::opcode_t'(s_axis_tdata[1:0]);
  assign in_idx = s_axis_tdata[11:2];
  assign in_x   = s_axis_tdata[27:12];
  assign in_y   = s_axis_tdata[43:28];

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign adv       = !out_valid || m_axis_tready;
  assign full      = (count >= rnlf_pkg::CNT_W'(rnlf_pkg::MAX_POINTS));
  assign link_fire = (state == rnlf_pkg::ST_WALK) && adv && cand.hit && (n_links < lim);
  assign last_link = link_fire && ((n_links + 1'b1) == lim);
  assign walk_empty = (j >= count) && !v_rd && !cand.busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (max_conn == '0) begin
      lim_calc = rnlf_pkg::LIM_W'(1);
    end else if (max_conn > rnlf_pkg::LIM_W'(rnlf_pkg::MAX_LINKS)) begin
      lim_calc = rnlf_pkg::LIM_W'(rnlf_pkg::MAX_LINKS);
    end else begin
      lim_calc = max_conn;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rnlf_pkg::ST_IDLE: begin
        if (in_fire && op == rnlf_pkg::OP_QUERY) begin
          state_next = rnlf_pkg::ST_QRD;
        end
      end
      rnlf_pkg::ST_QRD: begin
        if ({1'b0, qidx} >= rnlf_pkg::CNT_W'(count)) begin
          state_next = rnlf_pkg::ST_FIN;
        end else begin
          state_next = rnlf_pkg::ST_QLD;
        end
      end
      rnlf_pkg::ST_QLD: begin
        state_next = rnlf_pkg::ST_WALK;
      end
      rnlf_pkg::ST_WALK: begin
        if (last_link || walk_empty) begin
          state_next = rnlf_pkg::ST_FIN;
        end
      end
      rnlf_pkg::ST_FIN: begin
        if (adv) begin
          state_next = rnlf_pkg::ST_IDLE;
        end
      end
      default: state_next = rnlf_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    issue         = 1'b0;
    raddr         = j[rnlf_pkg::ADDR_W-1:0];
    case (state)
      rnlf_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      rnlf_pkg::ST_QRD: begin
        ram_re = 1'b1;
        raddr  = rnlf_pkg::ADDR_W'(qidx);
      end
      rnlf_pkg::ST_WALK: begin
        ram_re = adv;
        issue  = adv && (j < count);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rnlf_pkg::ST_IDLE;
      count    <= '0;
      radius   <= rnlf_pkg::RADIUS_W'(1024);
      max_conn <= rnlf_pkg::LIM_W'(4);
      pend_v   <= 1'b0;
      v_rd     <= 1'b0;
      n_links  <= '0;
      bad      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (rnlf_pkg::reg_index_t'(cfg_index))
          rnlf_pkg::REG_RADIUS:  radius   <= cfg_data[rnlf_pkg::RADIUS_W-1:0];
          rnlf_pkg::REG_MAXCONN: max_conn <= cfg_data[rnlf_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        case (op)
          rnlf_pkg::OP_CLEAR:  count <= '0;
          rnlf_pkg::OP_APPEND: if (!full) count <= count + 1'b1;
          rnlf_pkg::OP_QUERY: begin
            n_links <= '0;
            bad     <= 1'b0;
            pend_v  <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state == rnlf_pkg::ST_QRD && state_next == rnlf_pkg::ST_FIN) begin
        bad <= 1'b1;
      end
      if (state == rnlf_pkg::ST_WALK) begin
        if (adv) begin
          v_rd <= issue;
        end
        if (link_fire) begin
          n_links <= n_links + 1'b1;
          pend_v  <= 1'b1;
        end
      end else begin
        v_rd <= 1'b0;
      end
      if (state == rnlf_pkg::ST_FIN && adv) begin
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      qidx <= in_idx;
    end
    if (state == rnlf_pkg::ST_QRD) begin
      lim <= lim_calc;
      r2  <= radius * radius;
    end
    if (state == rnlf_pkg::ST_QLD) begin
      fx <= rdata[rnlf_pkg::COORD_W-1:0];
      fy <= rdata[2*rnlf_pkg::COORD_W-1:rnlf_pkg::COORD_W];
      j  <= '0;
    end else if (issue) begin
      j <= j + 1'b1;
    end
    if (link_fire) begin
      pend_x <= cand.x;
      pend_y <= cand.y;
    end
  end

  rnlf_point_ram u_ram (
    .clk   (clk),
    .we    (in_fire && op == rnlf_pkg::OP_APPEND && !full),
    .waddr (count[rnlf_pkg::ADDR_W-1:0]),
    .wdata ({in_y, in_x}),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  rnlf_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .flush    (state != rnlf_pkg::ST_WALK),
    .en       (adv),
    .in_valid (v_rd),
    .from_x   (fx),
    .from_y   (fy),
    .pt       (rdata),
    .r2       (r2),
    .cand     (cand)
  );

  // result beat select
  always_comb begin
    load_out = 1'b0;
    n_fx     = fx;
    n_fy     = fy;
    n_tx     = pend_x;
    n_ty     = pend_y;
    n_found  = 1'b1;
    n_last   = 1'b0;
    if (state == rnlf_pkg::ST_WALK) begin
      load_out = link_fire && pend_v;
    end else if (state == rnlf_pkg::ST_FIN) begin
      load_out = adv;
      n_last   = 1'b1;
      if (bad) begin
        n_fx    = '0;
        n_fy    = '0;
        n_tx    = '0;
        n_ty    = '0;
        n_found = 1'b0;
      end else if (!pend_v) begin
        n_tx    = '0;
        n_ty    = '0;
        n_found = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_fx    <= n_fx;
      o_fy    <= n_fy;
      o_tx    <= n_tx;
      o_ty    <= n_ty;
      o_found <= n_found;
      o_last  <= n_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {o_ty, o_tx, o_fy, o_fx};
  assign m_axis_tuser  = o_found;
  assign m_axis_tlast  = o_last;

  `RNLF_ASSERT_SAME(a_link_limit, clk, rst, state == rnlf_pkg::ST_WALK, n_links <= lim)
  `RNLF_ASSERT_SAME(a_count_cap, clk, rst, 1'b1, count <= rnlf_pkg::CNT_W'(rnlf_pkg::MAX_POINTS))
  `RNLF_ASSERT_SAME(a_pend_count, clk, rst, pend_v, n_links != '0)
  `RNLF_ASSERT_NEXT(a_fin_last, clk, rst, state == rnlf_pkg::ST_FIN && adv, m_axis_tvalid && m_axis_tlast)

endmodule
